FILE: rtl/lhm_pkg.sv
package lhm_pkg;

   // Sizing
   localparam int MAX_PEERS_DEF = 64;
   localparam int MODE_W        = 2;
   localparam int PEER_FIELD_W  = 6;
   localparam int TIME_W        = 32;
   localparam int CNT_W         = 16;
   localparam int PCT_W         = 7;
   localparam int NODE_W        = 7;
   localparam int HEALTH_W      = 2;
   localparam int NUM_W         = 23;   // holds 100 * 65535
   localparam int CSR_IDX_W     = 3;
   localparam int CSR_DATA_W    = 32;
   localparam int REQ_DATA_W    = 72;
   localparam int RSP_DATA_W    = 16;

   localparam logic [PCT_W-1:0] PCT_FULL = 7'd100;
   localparam logic [CNT_W-1:0] CNT_MAX  = 16'hFFFF;

   // Transaction kinds
   localparam logic [MODE_W-1:0] MODE_ACK   = 2'd0;
   localparam logic [MODE_W-1:0] MODE_START = 2'd1;
   localparam logic [MODE_W-1:0] MODE_END   = 2'd2;

   // Health codes
   localparam logic [HEALTH_W-1:0] HEALTH_OK          = 2'd0;
   localparam logic [HEALTH_W-1:0] HEALTH_BAD_PEER    = 2'd1;
   localparam logic [HEALTH_W-1:0] HEALTH_BAD_CLUSTER = 2'd2;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_MSG_PER_BURST = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GOOD_PCT      = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BAD_PCT       = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ACK_TIMEOUT   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_NODE_COUNT    = 3'd4;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ACK_WR,
      ST_RD,
      ST_LOAD,
      ST_DIV,
      ST_EVAL
   } state_type;

endpackage

FILE: rtl/lhm_ram.sv
module lhm_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/lhm_pct_div.sv
module lhm_pct_div
   import lhm_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] num,
   input  logic [CNT_W-1:0] den,
   output logic             done,
   output logic [PCT_W-1:0] quot
);

   localparam int STEP_W = $clog2(PCT_W);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [NUM_W-1:0]  rem_ff, rem_in;
   logic [CNT_W-1:0]  den_ff, den_in;
   logic [PCT_W-1:0]  quot_ff, quot_in;
   logic [NUM_W-1:0]  shifted;
   logic              fits;

   // One restoring step per cycle, most significant quotient bit first
   assign shifted = NUM_W'(den_ff) << step_ff;
   assign fits    = (rem_ff >= shifted);

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      quot_in = quot_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = STEP_W'(PCT_W - 1);
         rem_in  = num;
         den_in  = den;
         quot_in = '0;
      end else if (busy_ff) begin
         if (fits) begin
            rem_in = rem_ff - shifted;
         end
         quot_in = {quot_ff[PCT_W-2:0], fits};
         if (step_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            step_in = step_ff - STEP_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff <= step_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      quot_ff <= quot_in;
   end

   assign done = done_ff;
   assign quot = quot_ff;

endmodule

FILE: rtl/link_ack_health_monitor.sv
// Per-peer link health monitor.
// Input channel req_*: one transaction per event, kind in req_tuser (0 ack,
// 1 start of burst, 2 end of burst). Result channel rsp_*: one status
// transaction per peer after an end of burst, peers 1 to node_count-1 in
// order, rsp_tlast on the final one. The user writes the registers through
// csr_* only while the block is idle; the block itself does not enforce it.
// An ack that counts passes a counter read, then a write back; any other
// ack and a start of burst are taken in the idle state, as counters are
// cleared through per-entry valid bits. An end of burst walks all peers
// twice (find the cluster state, then update and report) with the shared
// percentage divider: per peer and pass the 7-step divider runs after the
// registered memory read unless the count reaches the burst size.
// The first status follows the first pass over all nodes (node_count, at
// most MAX_PEERS). No further transaction is taken until the walk ends.
// Reset is synchronous: registers take their defaults, and counters and
// statuses read as zero at once, with no clearing pass.
// A stall on rsp_tready holds the result register; the walk waits at the
// next report until the register is free.
module link_ack_health_monitor
   import lhm_pkg::*;
#(
   parameter int MAX_PEERS = MAX_PEERS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   // configuration
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   // input channel
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // tdata: peer_index[5:0], sent_time[37:6], now_time[69:38], zero[71:70]
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // tuser: mode[1:0]
   input  logic [MODE_W-1:0]     req_tuser,
   // result channel
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // tdata: result_peer[5:0], health[7:6], ack_percent[14:8], zero[15]
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tlast
);

   localparam int PEER_W = $clog2(MAX_PEERS);

   // Configuration registers
   logic [CNT_W-1:0]  mpb_ff;
   logic [PCT_W-1:0]  good_ff;
   logic [PCT_W-1:0]  bad_ff;
   logic [TIME_W-1:0] tout_ff;
   logic [NODE_W-1:0] nodes_ff;

   // Control state
   state_type            state_ff, state_in;
   logic [PEER_W-1:0]    n_ff, n_in;
   logic                 pass_ff, pass_in;
   logic                 bclu_ff, bclu_in;
   logic [MAX_PEERS-1:0] cnt_valid_ff, cnt_valid_in;
   logic [MAX_PEERS-1:0] hlt_valid_ff, hlt_valid_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   // Payload state
   logic [PEER_W-1:0]   rd_addr_ff;
   logic [HEALTH_W-1:0] hlt_ff, hlt_in;
   logic [PCT_W-1:0]    pct_ff, pct_in;
   logic [PEER_W-1:0]   rsp_peer_ff;
   logic [HEALTH_W-1:0] rsp_health_ff;
   logic [PCT_W-1:0]    rsp_pct_ff;
   logic                rsp_last_ff;
   logic [HEALTH_W-1:0] st_new;

   // Request fields
   logic [MODE_W-1:0]       req_mode;
   logic [PEER_FIELD_W-1:0] req_peer;
   logic [TIME_W-1:0]       req_sent;
   logic [TIME_W-1:0]       req_now;
   logic                    req_fire;
   logic                    ack_hit;

   // Memory ports
   logic [PEER_W-1:0]   rd_addr;
   logic                cnt_wr_en;
   logic [CNT_W-1:0]    cnt_wr_data;
   logic [CNT_W-1:0]    cnt_rdata;
   logic                hlt_wr_en;
   logic [HEALTH_W-1:0] hlt_rdata;
   logic [CNT_W-1:0]    cnt_cur;
   logic [HEALTH_W-1:0] hlt_cur;

   // Divider
   logic             div_start;
   logic [NUM_W-1:0] div_num;
   logic             div_done;
   logic [PCT_W-1:0] div_quot;

   logic [NODE_W-1:0] sz;
   logic              is_last;
   logic              rsp_load;

   assign req_mode = req_tuser;
   assign req_peer = req_tdata[5:0];
   assign req_sent = req_tdata[37:6];
   assign req_now  = req_tdata[69:38];
   assign req_fire = req_tvalid && req_tready;

   // Clamp the node count to the table depth
   assign sz = (nodes_ff > NODE_W'(MAX_PEERS)) ? NODE_W'(MAX_PEERS) : nodes_ff;
   assign is_last = (NODE_W'(n_ff) == sz - NODE_W'(1));

   // Ack counts only for a known peer and within the timeout
   assign ack_hit = (req_peer != '0) && (NODE_W'(req_peer) < sz) &&
                    ((req_now - req_sent) < tout_ff);

   // Entries not written since their clear read as zero
   assign cnt_cur = cnt_valid_ff[rd_addr_ff] ? cnt_rdata : '0;
   assign hlt_cur = hlt_valid_ff[rd_addr_ff] ? hlt_rdata : HEALTH_OK;
   assign div_num = NUM_W'(cnt_cur) * NUM_W'(PCT_FULL);

   assign rsp_load = (state_ff == ST_EVAL) && pass_ff && (!rsp_valid_ff || rsp_tready);

   // Hysteresis update of one peer's status
   always_comb begin
      st_new = hlt_ff;
      if (bclu_ff) begin
         st_new = HEALTH_BAD_CLUSTER;
      end else if ((pct_ff <= bad_ff) && (hlt_ff != HEALTH_BAD_PEER)) begin
         st_new = HEALTH_BAD_PEER;
      end else if ((pct_ff >= good_ff) && (hlt_ff != HEALTH_OK)) begin
         st_new = HEALTH_OK;
      end else if (hlt_ff == HEALTH_BAD_CLUSTER) begin
         st_new = (pct_ff <= bad_ff) ? HEALTH_BAD_PEER : HEALTH_OK;
      end
   end

   // Sequencer: next state, memory accesses and walk control
   always_comb begin
      state_in     = state_ff;
      n_in         = n_ff;
      pass_in      = pass_ff;
      bclu_in      = bclu_ff;
      cnt_valid_in = cnt_valid_ff;
      hlt_valid_in = hlt_valid_ff;
      hlt_in       = hlt_ff;
      pct_in       = pct_ff;
      rd_addr      = n_ff;
      cnt_wr_en    = 1'b0;
      cnt_wr_data  = cnt_cur + CNT_W'(1);
      hlt_wr_en    = 1'b0;
      div_start    = 1'b0;
      req_tready   = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            rd_addr    = req_peer[PEER_W-1:0];
            if (req_fire) begin
               unique case (req_mode)
                  MODE_ACK: begin
                     if (ack_hit) begin
                        state_in = ST_ACK_WR;
                     end
                  end
                  MODE_START: begin
                     cnt_valid_in = '0;
                  end
                  MODE_END: begin
                     if ((mpb_ff != '0) && (sz >= NODE_W'(2))) begin
                        n_in     = PEER_W'(1);
                        pass_in  = 1'b0;
                        bclu_in  = (sz > NODE_W'(2));
                        state_in = ST_RD;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_ACK_WR: begin
            // Saturating increment, written back to the entry just read
            if (cnt_cur != CNT_MAX) begin
               cnt_wr_en                = 1'b1;
               cnt_valid_in[rd_addr_ff] = 1'b1;
            end
            state_in = ST_IDLE;
         end
         ST_RD: begin
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            hlt_in = hlt_cur;
            if (cnt_cur >= mpb_ff) begin
               pct_in   = PCT_FULL;
               state_in = ST_EVAL;
            end else begin
               div_start = 1'b1;
               state_in  = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_done) begin
               pct_in   = div_quot;
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            if (!pass_ff) begin
               // First pass: any healthy peer clears the cluster flag
               if (pct_ff >= good_ff) begin
                  bclu_in = 1'b0;
               end
               if (is_last) begin
                  pass_in = 1'b1;
                  n_in    = PEER_W'(1);
               end else begin
                  n_in = n_ff + PEER_W'(1);
               end
               state_in = ST_RD;
            end else if (rsp_load) begin
               // Second pass: store the new status and report it
               hlt_wr_en          = 1'b1;
               hlt_valid_in[n_ff] = 1'b1;
               if (is_last) begin
                  state_in = ST_IDLE;
               end else begin
                  n_in     = n_ff + PEER_W'(1);
                  state_in = ST_RD;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Result register: load on report, drop on transaction
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         n_ff         <= '0;
         pass_ff      <= 1'b0;
         bclu_ff      <= 1'b0;
         cnt_valid_ff <= '0;
         hlt_valid_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         n_ff         <= n_in;
         pass_ff      <= pass_in;
         bclu_ff      <= bclu_in;
         cnt_valid_ff <= cnt_valid_in;
         hlt_valid_ff <= hlt_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Hold payload
   always_ff @(posedge clock) begin
      rd_addr_ff <= rd_addr;
      hlt_ff     <= hlt_in;
      pct_ff     <= pct_in;
      if (rsp_load) begin
         rsp_peer_ff   <= n_ff;
         rsp_health_ff <= st_new;
         rsp_pct_ff    <= pct_ff;
         rsp_last_ff   <= is_last;
      end
   end

   // Configuration writes; unknown indexes are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         mpb_ff   <= CNT_W'(0);
         good_ff  <= PCT_W'(80);
         bad_ff   <= PCT_W'(50);
         tout_ff  <= TIME_W'(200);
         nodes_ff <= NODE_W'(0);
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_MSG_PER_BURST: mpb_ff   <= csr_wdata[CNT_W-1:0];
            CSR_GOOD_PCT:      good_ff  <= csr_wdata[PCT_W-1:0];
            CSR_BAD_PCT:       bad_ff   <= csr_wdata[PCT_W-1:0];
            CSR_ACK_TIMEOUT:   tout_ff  <= csr_wdata[TIME_W-1:0];
            CSR_NODE_COUNT:    nodes_ff <= csr_wdata[NODE_W-1:0];
            default: begin
            end
         endcase
      end
   end

   lhm_ram #(
      .WIDTH (CNT_W),
      .DEPTH (MAX_PEERS)
   ) u_cnt_ram (
      .clock   (clock),
      .wr_en   (cnt_wr_en),
      .wr_addr (rd_addr_ff),
      .wr_data (cnt_wr_data),
      .rd_addr (rd_addr),
      .rd_data (cnt_rdata)
   );

   lhm_ram #(
      .WIDTH (HEALTH_W),
      .DEPTH (MAX_PEERS)
   ) u_hlt_ram (
      .clock   (clock),
      .wr_en   (hlt_wr_en),
      .wr_addr (n_ff),
      .wr_data (st_new),
      .rd_addr (rd_addr),
      .rd_data (hlt_rdata)
   );

   lhm_pct_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (mpb_ff),
      .done  (div_done),
      .quot  (div_quot)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_pct_ff, rsp_health_ff, PEER_FIELD_W'(rsp_peer_ff)};
   assign rsp_tlast  = rsp_last_ff;

endmodule

FILE: dv/testbench.sv
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import lhm_pkg::*;

   // Mode code the block must ignore
   localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
   // Quiet time before a register write: covers a full end-of-burst walk
   localparam int WALK_PAUSE = 1500;
   localparam int DRAIN_CYCLES = 100;
   localparam int REPORT_LIMIT = 50;

   typedef struct packed {
      logic [MODE_W-1:0]       mode;
      logic [PEER_FIELD_W-1:0] peer;
      logic [TIME_W-1:0]       sent;
      logic [TIME_W-1:0]       stamp;
   } link_event_type;

   typedef struct packed {
      logic [PEER_FIELD_W-1:0] peer;
      logic [HEALTH_W-1:0]     health;
      logic [PCT_W-1:0]        pct;
      logic                    last;
   } peer_report_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [MODE_W-1:0]     req_tuser = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tlast;

   // Register copies, at their reset values
   logic [15:0]         cfg_msg_per_burst = 16'd0;
   logic [PCT_W-1:0]    cfg_good_pct = 7'd80;
   logic [PCT_W-1:0]    cfg_bad_pct = 7'd50;
   logic [TIME_W-1:0]   cfg_ack_timeout = 32'd200;
   logic [NODE_W-1:0]   cfg_node_count = 7'd0;

   // Per-peer state of the health model
   logic [CNT_W-1:0]    ack_count [MAX_PEERS_DEF] = '{default: '0};
   logic [HEALTH_W-1:0] peer_status [MAX_PEERS_DEF] = '{default: '0};

   link_event_type  queued_events [$];
   peer_report_type awaited_reports [$];
   link_event_type  next_event;

   bit idle_enable = 1'b1;
   int send_gap = 0;
   int recv_stall = 0;
   int events_accepted = 0;
   int analyses_seen = 0;
   int reports_checked = 0;
   int mismatches = 0;

   link_ack_health_monitor DUT (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),   // peer_index, sent_time, now_time, zero pad
      .req_tuser  (req_tuser),   // mode
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),   // result_peer, health, ack_percent, zero pad
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Mostly short gaps, now and then a long one
   function automatic int draw_gap();
      int unsigned r;
      if (!idle_enable) return 0;
      r = $urandom_range(0, 15);
      if (r < 8) return 0;
      if (r < 14) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Apply one accepted event to the health model and queue its reports
   function automatic void predict_link_health(logic [MODE_W-1:0] mode,
                                               logic [PEER_FIELD_W-1:0] peer,
                                               logic [TIME_W-1:0] sent,
                                               logic [TIME_W-1:0] stamp);
      int unsigned         live;
      int unsigned         p;
      logic                cluster_down;
      logic [HEALTH_W-1:0] st;
      logic [PCT_W-1:0]    pct_of [MAX_PEERS_DEF];
      peer_report_type     rep;
      logic [TIME_W-1:0]   delay;
      live = (cfg_node_count > MAX_PEERS_DEF) ? MAX_PEERS_DEF : cfg_node_count;
      delay = stamp - sent;
      case (mode)
         MODE_ACK: begin
            if (peer >= 1 && peer < live && delay < cfg_ack_timeout &&
                ack_count[peer] != CNT_MAX)
               ack_count[peer] = ack_count[peer] + 1'b1;
         end
         MODE_START: begin
            foreach (ack_count[i]) ack_count[i] = '0;
         end
         MODE_END: begin
            if (cfg_msg_per_burst != 0 && live >= 2) begin
               // first pass: percentages and the cluster verdict
               cluster_down = (live > 2);
               for (int n = 1; n < live; n++) begin
                  p = (100 * ack_count[n]) / cfg_msg_per_burst;
                  if (p > PCT_FULL) p = PCT_FULL;
                  pct_of[n] = PCT_W'(p);
                  if (pct_of[n] >= cfg_good_pct) cluster_down = 1'b0;
               end
               // second pass: hysteresis update and one report per peer
               for (int n = 1; n < live; n++) begin
                  st = peer_status[n];
                  if (cluster_down)
                     st = HEALTH_BAD_CLUSTER;
                  else if (pct_of[n] <= cfg_bad_pct && st != HEALTH_BAD_PEER)
                     st = HEALTH_BAD_PEER;
                  else if (pct_of[n] >= cfg_good_pct && st != HEALTH_OK)
                     st = HEALTH_OK;
                  else if (st == HEALTH_BAD_CLUSTER)
                     st = (pct_of[n] <= cfg_bad_pct) ? HEALTH_BAD_PEER : HEALTH_OK;
                  peer_status[n] = st;
                  rep.peer = PEER_FIELD_W'(n);
                  rep.health = st;
                  rep.pct = pct_of[n];
                  rep.last = (n + 1 == live);
                  awaited_reports.push_back(rep);
               end
            end
         end
         default: ;
      endcase
   endfunction

   function automatic void compare_field(string name, int unsigned want,
                                         int unsigned got);
      if (want != got) begin
         if (mismatches < REPORT_LIMIT)
            $display("%0t: %s mismatch, expected %0d, actual %0d",
                     $time, name, want, got);
         mismatches++;
      end
   endfunction

   // Driver: present queued events, hold each until accepted
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         send_gap <= 0;
      end else begin
         if (req_tvalid && req_tready) begin
            predict_link_health(req_tuser, req_tdata[5:0], req_tdata[37:6],
                                req_tdata[69:38]);
            events_accepted++;
            if (req_tuser == MODE_END) analyses_seen++;
         end
         if (!req_tvalid || req_tready) begin
            if (send_gap != 0) begin
               req_tvalid <= 1'b0;
               send_gap <= send_gap - 1;
            end else if (queued_events.size() != 0) begin
               next_event = queued_events.pop_front();
               req_tvalid <= 1'b1;
               req_tuser <= next_event.mode;
               req_tdata <= {2'b00, next_event.stamp, next_event.sent, next_event.peer};
               send_gap <= draw_gap();
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Monitor: check each status transaction against the oldest report
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         recv_stall <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (awaited_reports.size() == 0) begin
               if (mismatches < REPORT_LIMIT)
                  $display("%0t: unexpected status transaction, actual peer %0d",
                           $time, rsp_tdata[5:0]);
               mismatches++;
            end else begin
               compare_field("result_peer", awaited_reports[0].peer, rsp_tdata[5:0]);
               compare_field("health", awaited_reports[0].health, rsp_tdata[7:6]);
               compare_field("ack_percent", awaited_reports[0].pct, rsp_tdata[14:8]);
               compare_field("last", awaited_reports[0].last, rsp_tlast);
               void'(awaited_reports.pop_front());
               reports_checked++;
            end
         end
         if (recv_stall != 0) begin
            rsp_tready <= 1'b0;
            recv_stall <= recv_stall - 1;
         end else begin
            rsp_tready <= 1'b1;
            recv_stall <= draw_gap();
         end
      end
   end

   task automatic push_event(logic [MODE_W-1:0] mode, logic [PEER_FIELD_W-1:0] peer,
                             logic [TIME_W-1:0] sent, logic [TIME_W-1:0] stamp);
      link_event_type ev;
      ev.mode = mode;
      ev.peer = peer;
      ev.sent = sent;
      ev.stamp = stamp;
      queued_events.push_back(ev);
   endtask

   // Ack with a round trip inside or outside the current timeout
   task automatic push_ack(logic [PEER_FIELD_W-1:0] peer, bit timely);
      logic [TIME_W-1:0] stamp;
      logic [TIME_W-1:0] delay;
      stamp = $urandom;
      if (cfg_ack_timeout == 0)
         delay = $urandom;
      else if (timely)
         delay = ($urandom_range(0, 7) == 0) ? cfg_ack_timeout - 1 :
                 $urandom_range(0, cfg_ack_timeout - 1);
      else
         delay = ($urandom_range(0, 3) == 0) ? cfg_ack_timeout :
                 cfg_ack_timeout + $urandom_range(0, ~cfg_ack_timeout);
      push_event(MODE_ACK, peer, stamp - delay, stamp);
   endtask

   // Hold until every event is taken and every report is in, then let a walk end
   task automatic wait_idle();
      while (queued_events.size() != 0 || req_tvalid || awaited_reports.size() != 0)
         @(negedge clock);
      repeat (WALK_PAUSE) @(negedge clock);
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_MSG_PER_BURST: cfg_msg_per_burst = value[15:0];
         CSR_GOOD_PCT:      cfg_good_pct = value[PCT_W-1:0];
         CSR_BAD_PCT:       cfg_bad_pct = value[PCT_W-1:0];
         CSR_ACK_TIMEOUT:   cfg_ack_timeout = value;
         CSR_NODE_COUNT:    cfg_node_count = value[NODE_W-1:0];
         default: ;
      endcase
   endtask

   task automatic configure(logic [15:0] msg, logic [PCT_W-1:0] good,
                            logic [PCT_W-1:0] bad, logic [TIME_W-1:0] tmo,
                            logic [NODE_W-1:0] nodes);
      wait_idle();
      write_csr(CSR_MSG_PER_BURST, msg);
      write_csr(CSR_GOOD_PCT, good);
      write_csr(CSR_BAD_PCT, bad);
      write_csr(CSR_ACK_TIMEOUT, tmo);
      write_csr(CSR_NODE_COUNT, nodes);
      @(negedge clock);
   endtask

   // Mostly whole bursts with random ack counts per peer, some stray events
   task automatic gen_traffic(int budget);
      int left;
      int live;
      int hi;
      int cap;
      int hits;
      left = budget;
      while (left > 0) begin
         if ($urandom_range(0, 9) == 0) begin
            push_event(MODE_W'($urandom_range(0, 3)),
                       PEER_FIELD_W'($urandom_range(0, 63)), $urandom, $urandom);
            left--;
         end else begin
            live = (cfg_node_count > MAX_PEERS_DEF) ? MAX_PEERS_DEF : cfg_node_count;
            hi = (live >= 2) ? live - 1 : 3;
            cap = (cfg_msg_per_burst > 12) ? 3 : cfg_msg_per_burst + 1;
            // now and then carry counts over from the previous burst
            if ($urandom_range(0, 3) != 0) begin
               push_event(MODE_START, PEER_FIELD_W'($urandom_range(0, 63)),
                          $urandom, $urandom);
               left--;
            end
            for (int p = 1; p <= hi; p++) begin
               hits = $urandom_range(0, cap);
               repeat (hits) begin
                  push_ack(PEER_FIELD_W'(p), $urandom_range(0, 7) != 0);
                  left--;
               end
            end
            // acks for self or for a peer outside the node list
            if ($urandom_range(0, 3) == 0) begin
               if (live >= MAX_PEERS_DEF || $urandom_range(0, 1) == 0)
                  push_ack(6'd0, 1'b1);
               else
                  push_ack(PEER_FIELD_W'($urandom_range(live, 63)), 1'b1);
               left--;
            end
            push_event(MODE_END, PEER_FIELD_W'($urandom_range(0, 63)), $urandom, $urandom);
            left--;
         end
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Reset settings: no nodes, analysis off
      push_event(MODE_END, 6'd1, 32'd0, 32'd0);
      push_ack(6'd1, 1'b1);

      // Directed burst with hand-picked counts
      configure(16'd4, 7'd75, 7'd25, 32'd200, 7'd5);
      push_event(MODE_UNUSED, 6'd63, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      push_event(MODE_START, 6'd0, 32'd0, 32'd0);
      push_event(MODE_ACK, 6'd0, 32'd0, 32'd10);
      push_event(MODE_ACK, 6'd5, 32'd0, 32'd10);
      push_event(MODE_ACK, 6'd63, 32'd0, 32'd10);
      push_event(MODE_ACK, 6'd1, 32'd1000, 32'd1199);
      push_event(MODE_ACK, 6'd1, 32'd1000, 32'd1200);
      push_event(MODE_ACK, 6'd1, 32'hFFFF_FFF0, 32'h0000_000F);
      push_event(MODE_ACK, 6'd2, 32'd0, 32'd0);
      repeat (5) push_event(MODE_ACK, 6'd3, 32'd77, 32'd100);
      push_event(MODE_END, 6'd0, 32'd0, 32'd0);
      // empty burst drives the whole cluster bad
      push_event(MODE_START, 6'd0, 32'd0, 32'd0);
      push_event(MODE_END, 6'd0, 32'd0, 32'd0);
      // one peer recovers, the others leave the bad-cluster state
      repeat (3) push_event(MODE_ACK, 6'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      push_event(MODE_END, 6'd0, 32'd0, 32'd0);
      push_event(MODE_START, 6'd0, 32'd0, 32'd0);

      // Random bursts over a range of settings
      configure(16'd8, 7'd80, 7'd50, 32'd200, 7'd6);
      gen_traffic(45);
      configure(16'd1, 7'd100, 7'd0, 32'hFFFF_FFFF, 7'd2);
      gen_traffic(30);
      configure(16'd65535, 7'd0, 7'd100, 32'd0, 7'd64);
      gen_traffic(40);
      configure(16'd3, 7'd67, 7'd33, 32'd1000, 7'd64);
      gen_traffic(60);
      configure(16'd0, 7'd80, 7'd50, 32'd200, 7'd7);
      gen_traffic(20);
      configure(16'd5, 7'd60, 7'd30, 32'd500, 7'd1);
      gen_traffic(15);
      configure(16'd10, 7'd70, 7'd40, 32'd300, 7'd9);
      idle_enable = 1'b0;
      gen_traffic(40);
      wait_idle();
      idle_enable = 1'b1;
      repeat (3) begin
         configure(16'($urandom_range(1, 12)), PCT_W'($urandom_range(0, 100)),
                   PCT_W'($urandom_range(0, 100)), $urandom,
                   NODE_W'($urandom_range(3, 12)));
         gen_traffic(30);
      end

      // Drain
      while (queued_events.size() != 0 || req_tvalid || awaited_reports.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d request transactions with %0d burst analyses, node counts 0 to 64,",
               events_accepted, analyses_seen);
      $display("with random stalls on both sides; %0d status reports checked, %0d mismatches.",
               reports_checked, mismatches);
      if (mismatches == 0)
         $display("link_ack_health_monitor test passed");
      else
         $display("link_ack_health_monitor test failed");
      $finish;
   end

   // Watchdog
   initial begin
      #150ms;
      $display("Timed out with %0d status reports outstanding", awaited_reports.size());
      $display("link_ack_health_monitor test failed");
      $finish;
   end

endmodule

FILE: files.f
rtl/lhm_pkg.sv
rtl/lhm_ram.sv
rtl/lhm_pct_div.sv
rtl/link_ack_health_monitor.sv
dv/testbench.sv
